@@ rtl/hrrn_pkg.sv @@
// ============================================================================
// hrrn_pkg
// Shared types and constants of the ready-queue scheduler.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package hrrn_pkg;

    // field widths
    localparam int PID_W   = 16;
    localparam int TIME_W  = 32;
    localparam int EST_W   = 24;
    localparam int ALPHA_W = 9;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // multiplier pair operand widths
    localparam int MUL_A_W = TIME_W + 1;
    localparam int MUL_B_W = EST_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // request function codes
    localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DISP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPD  = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST = 2'd2;

    // configuration reset values
    localparam logic               POLICY_RST   = 1'b1;
    localparam logic [ALPHA_W-1:0] ALPHA_RST    = 9'd128;
    localparam logic [EST_W-1:0]   INIT_EST_RST = 24'd10000;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 9'd256;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PID_W-1:0]  proc_id;
        logic [TIME_W-1:0] now;
        logic [EST_W-1:0]  burst_estimate;
        logic [EST_W-1:0]  last_burst;
    } t_in_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PID_W-1:0]  chosen_id;
        logic [EST_W-1:0]  estimate_out;
    } t_out_rsp;

    // one queue table entry
    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [TIME_W-1:0] ready_time;
        logic [EST_W-1:0]  estimate;
    } t_entry;

    typedef struct packed {
        logic               load;
        logic [MUL_A_W-1:0] a0;
        logic [MUL_B_W-1:0] b0;
        logic [MUL_A_W-1:0] a1;
        logic [MUL_B_W-1:0] b1;
    } t_mul_req;

    typedef struct packed {
        logic              gt;
        logic [PROD_W:0]   sum;
    } t_mul_rsp;

endpackage

`default_nettype wire

@@ rtl/hrrn_entry_ram.sv @@
// ============================================================================
// hrrn_entry_ram
// Queue table: one write port, one read port, registered read data.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hrrn_entry_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire hrrn_pkg::t_entry i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output hrrn_pkg::t_entry      o_rdata
);

    hrrn_pkg::t_entry r_mem [DEPTH];
    hrrn_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/hrrn_mul_pair.sv @@
// ============================================================================
// hrrn_mul_pair
// Two registered multipliers with compare and sum of the products.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module hrrn_mul_pair (
    input  wire logic               i_clk,
    input  wire hrrn_pkg::t_mul_req i_req,
    output hrrn_pkg::t_mul_rsp      o_rsp
);

    logic [hrrn_pkg::PROD_W-1:0] r_p0;
    logic [hrrn_pkg::PROD_W-1:0] r_p1;

    // product registers
    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_p0 <= hrrn_pkg::PROD_W'(i_req.a0) * hrrn_pkg::PROD_W'(i_req.b0);
            r_p1 <= hrrn_pkg::PROD_W'(i_req.a1) * hrrn_pkg::PROD_W'(i_req.b1);
        end
    end

    // ratio compare and weighted sum
    assign o_rsp.gt  = (r_p0 > r_p1);
    assign o_rsp.sum = {1'b0, r_p0} + {1'b0, r_p1};

endmodule

`default_nettype wire

@@ rtl/hrrn_ready_queue_scheduler_top.sv @@
// ============================================================================
// hrrn_ready_queue_scheduler_top
// Ready-queue scheduler with FIFO or highest-response-ratio dispatch.
// ============================================================================
// channel  | valid       | flow ctrl    | payload / fields
// ---------+-------------+--------------+--------------------------------
// request  | i_in_valid  | o_in_stall   | i_in_req  (t_in_req)
// result   | o_out_valid | i_out_stall  | o_out_rsp (t_out_rsp)
// config   | i_cfg_valid | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Dispatch time grows with the entry count and with the entries behind the
// chosen one, set by the single table read port and, for ratio dispatch,
// by the multiply-then-compare loop.
// Reset clears the entry count and configuration; table contents are not
// cleared. One request is in work at a time; a held result does not block
// the next request from being taken, only the hand-off of its result.
`timescale 1ns / 1ps
`default_nettype none

module hrrn_ready_queue_scheduler_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire hrrn_pkg::t_in_req                   i_in_req,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output hrrn_pkg::t_out_rsp                       o_out_rsp,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [hrrn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [hrrn_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_UPD   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // control registers
    logic [2:0]                     r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic                           r_out_valid, n_out_valid;
    logic                           r_policy;
    logic [hrrn_pkg::ALPHA_W-1:0]   r_alpha;
    logic [hrrn_pkg::EST_W-1:0]     r_init_est;

    // payload registers
    hrrn_pkg::t_in_req              r_req, n_req;
    hrrn_pkg::t_out_rsp             r_res, n_res;
    hrrn_pkg::t_out_rsp             r_out, n_out;
    logic [AW-1:0]                  r_idx, n_idx;
    logic [AW-1:0]                  r_ptr, n_ptr;
    logic [AW-1:0]                  r_best_idx, n_best_idx;
    logic [hrrn_pkg::PID_W-1:0]     r_best_pid, n_best_pid;
    logic [hrrn_pkg::EST_W-1:0]     r_best_est, n_best_est;
    logic [hrrn_pkg::MUL_A_W-1:0]   r_best_sum, n_best_sum;
    logic [hrrn_pkg::PID_W-1:0]     r_cand_pid, n_cand_pid;
    logic [hrrn_pkg::EST_W-1:0]     r_cand_est, n_cand_est;
    logic [hrrn_pkg::MUL_A_W-1:0]   r_cand_sum, n_cand_sum;

    // table and multiplier connections
    logic                           w_we, w_re;
    logic [AW-1:0]                  w_waddr, w_raddr;
    hrrn_pkg::t_entry               w_wdata, w_rdata;
    hrrn_pkg::t_mul_req             w_mul_req;
    hrrn_pkg::t_mul_rsp             w_mul_rsp;

    logic [hrrn_pkg::MUL_A_W-1:0]   w_rd_sum;
    logic [hrrn_pkg::ALPHA_W-1:0]   w_alpha_sat;
    logic [CW:0]                    w_cnt_x;
    logic [CW:0]                    w_idx_p1;
    logic [CW:0]                    w_ptr_p2;

    hrrn_entry_ram #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hrrn_mul_pair u_mul (
        .i_clk (i_clk),
        .i_req (w_mul_req),
        .o_rsp (w_mul_rsp)
    );

    // wait plus estimate of the entry just read
    assign w_rd_sum = {1'b0, r_req.now - w_rdata.ready_time}
                    + hrrn_pkg::MUL_A_W'(w_rdata.estimate);
    assign w_alpha_sat = (r_alpha > hrrn_pkg::ALPHA_ONE) ? hrrn_pkg::ALPHA_ONE : r_alpha;
    assign w_cnt_x  = (CW+1)'(r_count);
    assign w_idx_p1 = (CW+1)'(r_idx) + (CW+1)'(1);
    assign w_ptr_p2 = (CW+1)'(r_ptr) + (CW+1)'(2);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign o_cfg_ready = 1'b1;

    // request sequencer
    always_comb begin
        logic [AW-1:0] v_sel;
        logic          v_start_rm;
        logic          v_finish;
        logic [CW:0]   v_sel_p1;

        v_sel      = '0;
        v_start_rm = 1'b0;
        v_finish   = 1'b0;
        n_state    = r_state;
        n_count    = r_count;
        n_req      = r_req;
        n_res      = r_res;
        n_out      = r_out;
        n_idx      = r_idx;
        n_ptr      = r_ptr;
        n_best_idx = r_best_idx;
        n_best_pid = r_best_pid;
        n_best_est = r_best_est;
        n_best_sum = r_best_sum;
        n_cand_pid = r_cand_pid;
        n_cand_est = r_cand_est;
        n_cand_sum = r_cand_sum;
        w_we       = 1'b0;
        w_waddr    = '0;
        w_wdata    = '0;
        w_re       = 1'b0;
        w_raddr    = '0;
        w_mul_req  = '0;

        // result register drains on its own handshake
        n_out_valid = r_out_valid && i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req = i_in_req;
                    unique case (i_in_req.func)
                        hrrn_pkg::FUNC_ENQ: begin
                            if (r_count == CW'(QUEUE_DEPTH)) begin
                                n_res = '{hrrn_pkg::ST_FULL, '0, '0};
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_count[AW-1:0];
                                w_wdata.pid        = i_in_req.proc_id;
                                w_wdata.ready_time = i_in_req.now;
                                w_wdata.estimate   = (i_in_req.burst_estimate == '0) ?
                                                     r_init_est : i_in_req.burst_estimate;
                                n_count = r_count + CW'(1);
                                n_res   = '{hrrn_pkg::ST_OK, '0, '0};
                            end
                            n_state = S_DONE;
                        end
                        hrrn_pkg::FUNC_DISP: begin
                            if (r_count == '0) begin
                                n_res   = '{hrrn_pkg::ST_EMPTY, '0, '0};
                                n_state = S_DONE;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = '0;
                                n_state = S_LOAD;
                            end
                        end
                        hrrn_pkg::FUNC_UPD: begin
                            w_mul_req.load = 1'b1;
                            w_mul_req.a0   = hrrn_pkg::MUL_A_W'(w_alpha_sat);
                            w_mul_req.b0   = i_in_req.last_burst;
                            w_mul_req.a1   = hrrn_pkg::MUL_A_W'(hrrn_pkg::ALPHA_ONE - w_alpha_sat);
                            w_mul_req.b1   = i_in_req.burst_estimate;
                            n_state        = S_UPD;
                        end
                        default: begin
                            n_res   = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                // head entry is the first best
                n_best_pid = w_rdata.pid;
                n_best_est = w_rdata.estimate;
                n_best_sum = w_rd_sum;
                n_best_idx = '0;
                if (r_policy && (r_count > CW'(1))) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(1);
                    n_idx   = AW'(1);
                    n_state = S_MUL;
                end else begin
                    v_sel      = '0;
                    v_start_rm = 1'b1;
                end
            end
            S_MUL: begin
                // cross products of candidate and best, prefetch next entry
                n_cand_pid     = w_rdata.pid;
                n_cand_est     = w_rdata.estimate;
                n_cand_sum     = w_rd_sum;
                w_mul_req.load = 1'b1;
                w_mul_req.a0   = w_rd_sum;
                w_mul_req.b0   = r_best_est;
                w_mul_req.a1   = r_best_sum;
                w_mul_req.b1   = w_rdata.estimate;
                if (w_idx_p1 < w_cnt_x) begin
                    w_re    = 1'b1;
                    w_raddr = r_idx + AW'(1);
                end
                n_state = S_CMP;
            end
            S_CMP: begin
                // strict compare keeps the earlier entry on a tie
                if (w_mul_rsp.gt) begin
                    n_best_pid = r_cand_pid;
                    n_best_est = r_cand_est;
                    n_best_sum = r_cand_sum;
                    n_best_idx = r_idx;
                end
                if (w_idx_p1 < w_cnt_x) begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_MUL;
                end else begin
                    v_sel      = w_mul_rsp.gt ? r_idx : r_best_idx;
                    v_start_rm = 1'b1;
                end
            end
            S_SHIFT: begin
                // move entry ptr+1 down to ptr, read the one after
                w_we    = 1'b1;
                w_waddr = r_ptr;
                w_wdata = w_rdata;
                if (w_ptr_p2 < w_cnt_x) begin
                    w_re    = 1'b1;
                    w_raddr = r_ptr + AW'(2);
                    n_ptr   = r_ptr + AW'(1);
                end else begin
                    v_finish = 1'b1;
                end
            end
            S_UPD: begin
                n_res   = '{hrrn_pkg::ST_OK, '0, w_mul_rsp.sum[8 +: hrrn_pkg::EST_W]};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // start removal of the chosen entry
        v_sel_p1 = (CW+1)'(v_sel) + (CW+1)'(1);
        if (v_start_rm) begin
            if (v_sel_p1 < w_cnt_x) begin
                w_re    = 1'b1;
                w_raddr = v_sel + AW'(1);
                n_ptr   = v_sel;
                n_state = S_SHIFT;
            end else begin
                v_finish = 1'b1;
            end
        end

        // dispatch complete
        if (v_finish) begin
            n_count = r_count - CW'(1);
            n_res   = '{hrrn_pkg::ST_OK, n_best_pid, n_best_est};
            n_state = S_DONE;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy   <= hrrn_pkg::POLICY_RST;
            r_alpha    <= hrrn_pkg::ALPHA_RST;
            r_init_est <= hrrn_pkg::INIT_EST_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hrrn_pkg::CFG_POLICY:   r_policy   <= i_cfg_data[0];
                hrrn_pkg::CFG_ALPHA:    r_alpha    <= i_cfg_data[hrrn_pkg::ALPHA_W-1:0];
                hrrn_pkg::CFG_INIT_EST: r_init_est <= i_cfg_data[hrrn_pkg::EST_W-1:0];
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_res      <= n_res;
        r_out      <= n_out;
        r_idx      <= n_idx;
        r_ptr      <= n_ptr;
        r_best_idx <= n_best_idx;
        r_best_pid <= n_best_pid;
        r_best_est <= n_best_est;
        r_best_sum <= n_best_sum;
        r_cand_pid <= n_cand_pid;
        r_cand_est <= n_cand_est;
        r_cand_sum <= n_cand_sum;
    end

    // entry count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count beyond table depth");

    // an accepted request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // shifting only touches live entries
    a_shift_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (((CW+1)'(r_ptr) + (CW+1)'(1)) < w_cnt_x))
        else $error("shift beyond last entry");

    // a scan position stays below the entry count
    a_scan_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL) || (r_state == S_CMP)) |-> ((CW+1)'(r_idx) < w_cnt_x))
        else $error("ratio scan beyond last entry");

endmodule

`default_nettype wire

@@ tb/hrrn_sched_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hrrn_sched_checker
// Watches the request, result and register channels of the ready-queue
// scheduler, keeps its own copy of the queue table and registers, works out
// the reply to every accepted request and compares each accepted result
// with the oldest reply still waiting.
// ============================================================================

module hrrn_sched_checker #(
    parameter int QDEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  hrrn_pkg::t_in_req                   i_in_req,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  hrrn_pkg::t_out_rsp                  i_out_rsp,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [hrrn_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hrrn_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_pending,
    output int                                  o_fail_count,
    output int                                  o_checked,
    output int                                  o_full_seen,
    output int                                  o_empty_seen
);
    import hrrn_pkg::*;

    localparam int MAX_REPORTS = 10;

    // shadow registers
    logic               policy_hrrn;
    logic [ALPHA_W-1:0] alpha_w;
    logic [EST_W-1:0]   init_est;

    // shadow queue table in admission order
    logic [PID_W-1:0]   tbl_pid   [QDEPTH];
    logic [TIME_W-1:0]  tbl_ready [QDEPTH];
    logic [EST_W-1:0]   tbl_est   [QDEPTH];
    int                 entry_count;

    t_out_rsp           expected_replies[$];
    t_out_rsp           want;

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        o_checked    = 0;
        o_full_seen  = 0;
        o_empty_seen = 0;
    end

    // reply to one request, updating the shadow table
    function automatic t_out_rsp predict_sched_reply(t_in_req rq);
        t_out_rsp          rsp;
        logic [TIME_W-1:0] age;
        longint unsigned   best_wait, best_est, cand_wait, cand_est, wgt, mix;
        int                sel;
        rsp = '0;
        case (rq.func)
            FUNC_ENQ: begin
                if (entry_count >= QDEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    tbl_pid[entry_count]   = rq.proc_id;
                    tbl_ready[entry_count] = rq.now;
                    tbl_est[entry_count]   = (rq.burst_estimate == '0) ? init_est
                                                                        : rq.burst_estimate;
                    entry_count++;
                end
            end
            FUNC_DISP: begin
                if (entry_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    sel = 0;
                    if (policy_hrrn) begin
                        // wait wraps modulo 2^32 before widening
                        age       = rq.now - tbl_ready[0];
                        best_wait = age;
                        best_est  = tbl_est[0];
                        for (int i = 1; i < entry_count; i++) begin
                            age       = rq.now - tbl_ready[i];
                            cand_wait = age;
                            cand_est  = tbl_est[i];
                            // strict compare keeps the earlier entry on a tie
                            if ((cand_wait + cand_est) * best_est >
                                (best_wait + best_est) * cand_est) begin
                                sel       = i;
                                best_wait = cand_wait;
                                best_est  = cand_est;
                            end
                        end
                    end
                    rsp.chosen_id    = tbl_pid[sel];
                    rsp.estimate_out = tbl_est[sel];
                    for (int i = sel; i + 1 < entry_count; i++) begin
                        tbl_pid[i]   = tbl_pid[i + 1];
                        tbl_ready[i] = tbl_ready[i + 1];
                        tbl_est[i]   = tbl_est[i + 1];
                    end
                    entry_count--;
                end
            end
            FUNC_UPD: begin
                wgt = (alpha_w > ALPHA_ONE) ? ALPHA_ONE : alpha_w;
                mix = wgt * rq.last_burst + (256 - wgt) * rq.burst_estimate;
                rsp.estimate_out = EST_W'(mix >> 8);
            end
            default: ;
        endcase
        return rsp;
    endfunction

    // register writes, prediction and result compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            policy_hrrn = POLICY_RST;
            alpha_w     = ALPHA_RST;
            init_est    = INIT_EST_RST;
            entry_count = 0;
            expected_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_POLICY:   policy_hrrn = i_cfg_data[0];
                    CFG_ALPHA:    alpha_w     = i_cfg_data[ALPHA_W-1:0];
                    CFG_INIT_EST: init_est    = i_cfg_data[EST_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expected_replies.push_back(predict_sched_reply(i_in_req));
            end
            if (i_out_valid && !i_out_stall) begin
                o_checked++;
                if (expected_replies.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_REPORTS) begin
                        $display("[%0t] result with no request waiting: status %0d id %0d est %0d",
                                 $realtime, i_out_rsp.status, i_out_rsp.chosen_id,
                                 i_out_rsp.estimate_out);
                    end
                end else begin
                    want = expected_replies.pop_front();
                    if (want.status == ST_FULL) o_full_seen++;
                    if (want.status == ST_EMPTY) o_empty_seen++;
                    if (i_out_rsp.status !== want.status ||
                        i_out_rsp.chosen_id !== want.chosen_id ||
                        i_out_rsp.estimate_out !== want.estimate_out) begin
                        o_fail_count++;
                        if (o_fail_count <= MAX_REPORTS) begin
                            $display("[%0t] result mismatch: expected status %0d id %0d est %0d, got status %0d id %0d est %0d",
                                     $realtime, want.status, want.chosen_id, want.estimate_out,
                                     i_out_rsp.status, i_out_rsp.chosen_id,
                                     i_out_rsp.estimate_out);
                        end
                    end
                end
            end
        end
        o_pending <= expected_replies.size();
    end

endmodule

@@ tb/tb_hrrn_ready_queue_scheduler_top.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_hrrn_ready_queue_scheduler_top
// Drives the ready-queue scheduler with a short directed sequence and then
// runs of enqueue, dispatch and estimate-update requests under six register
// settings, with random idling on both channels in the first four; a checker beside the block
// predicts and compares every result.
// ============================================================================

module tb_hrrn_ready_queue_scheduler_top;
    import hrrn_pkg::*;

    localparam int QDEPTH          = 16;
    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int TAIL_CYCLES     = 64;

    // the block defines no name for the unused function code
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_req               in_req    = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic                  in_stall;
    logic                  out_valid;
    t_out_rsp              out_rsp;
    logic                  cfg_ready;

    int                    pending, fail_count, checked, full_seen, empty_seen;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    sent_count     = 0;
    int                    cycle_count    = 0;
    logic [TIME_W-1:0]     clock_ms       = '0;

    always #5 clk = ~clk;

    hrrn_ready_queue_scheduler_top #(
        .QUEUE_DEPTH (QDEPTH)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    hrrn_sched_checker #(
        .QDEPTH (QDEPTH)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_rsp    (out_rsp),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_checked    (checked),
        .o_full_seen  (full_seen),
        .o_empty_seen (empty_seen)
    );

    // result side back-pressure
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_in_req build_req(logic [FUNC_W-1:0] f, logic [PID_W-1:0] pid,
                                          logic [TIME_W-1:0] now, logic [EST_W-1:0] est,
                                          logic [EST_W-1:0] burst);
        t_in_req r;
        r.func           = f;
        r.proc_id        = pid;
        r.now            = now;
        r.burst_estimate = est;
        r.last_burst     = burst;
        return r;
    endfunction

    // estimates lean toward zero, small values and the extremes
    function automatic logic [EST_W-1:0] rand_est();
        case ($urandom_range(9))
            0, 1, 2: return '0;
            3, 4, 5: return EST_W'($urandom_range(1, 20000));
            6:       return '1;
            7:       return EST_W'(1);
            default: return EST_W'($urandom());
        endcase
    endfunction

    // random request; time mostly moves forward, sometimes jumps anywhere
    function automatic t_in_req make_random_req(logic [FUNC_W-1:0] f);
        logic [TIME_W-1:0] now;
        if ($urandom_range(49) == 0) clock_ms = $urandom();
        else clock_ms = clock_ms + $urandom_range(0, 3000);
        now = ($urandom_range(19) == 0) ? TIME_W'($urandom()) : clock_ms;
        return build_req(f, PID_W'($urandom_range(0, 65535)), now, rand_est(), rand_est());
    endfunction

    // one request through the valid/stall handshake
    task automatic send_req(input t_in_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent_count++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin send_idle_pct = 22; recv_stall_pct = 60; end
            1: begin send_idle_pct = 60; recv_stall_pct = 22; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    // runs of enqueues, dispatches and other requests so the queue swings between empty and full
    task automatic random_traffic(input int n_items);
        int                done;
        int                kind;
        int                run_len;
        logic [FUNC_W-1:0] f;
        done = 0;
        while (done < n_items) begin
            kind    = $urandom_range(9);
            run_len = $urandom_range(1, 12);
            for (int k = 0; k < run_len && done < n_items; k++) begin
                if (kind < 4) f = FUNC_ENQ;
                else if (kind < 8) f = FUNC_DISP;
                else if (kind == 9) f = FUNC_UPD;
                else f = FUNC_W'($urandom_range(3));
                send_req(make_random_req(f));
                done++;
            end
        end
    endtask

    // directed corner cases at reset settings (ratio dispatch, alpha 128)
    task automatic directed_part();
        send_req(build_req(FUNC_DISP, '0, '0, '0, '0));
        send_req(build_req(FUNC_UNUSED, '1, '1, '1, '1));
        send_req(build_req(FUNC_UPD, '0, '0, '0, '1));
        send_req(build_req(FUNC_UPD, '0, '0, '1, '1));
        send_req(build_req(FUNC_UPD, '0, '0, '1, '0));
        // zero estimate takes the initial one; wrapped wait on the second entry
        send_req(build_req(FUNC_ENQ, '0, '0, '0, '0));
        send_req(build_req(FUNC_ENQ, '1, '1, '1, '0));
        // equal ratios: the earlier entry must win
        send_req(build_req(FUNC_ENQ, PID_W'(5), TIME_W'(100), EST_W'(100), '0));
        send_req(build_req(FUNC_ENQ, PID_W'(6), TIME_W'(100), EST_W'(100), '0));
        send_req(build_req(FUNC_DISP, '0, TIME_W'(200), '0, '0));
        // fill the table and push one past full
        for (int i = 0; i < QDEPTH - 2; i++) begin
            send_req(build_req(FUNC_ENQ, PID_W'(100 + i), TIME_W'(300 + i * 7),
                               EST_W'(i + 1), '0));
        end
        send_req(build_req(FUNC_DISP, '0, '1, '0, '0));
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(0);
        directed_part();
        drain_block();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            set_idling(ph / 2);
            case (ph)
                0: begin
                    cfg_write(CFG_POLICY, CFG_DATA_W'(0));
                    cfg_write(CFG_ALPHA, CFG_DATA_W'(0));
                    cfg_write(CFG_INIT_EST, CFG_DATA_W'(1));
                end
                1: begin
                    cfg_write(CFG_POLICY, CFG_DATA_W'(1));
                    cfg_write(CFG_ALPHA, CFG_DATA_W'(ALPHA_ONE));
                    cfg_write(CFG_INIT_EST, CFG_DATA_W'(24'hFFFFFF));
                end
                2: begin
                    // zero initial estimate gives entries with estimate zero
                    cfg_write(CFG_POLICY, CFG_DATA_W'(1));
                    cfg_write(CFG_ALPHA, CFG_DATA_W'($urandom_range(0, 256)));
                    cfg_write(CFG_INIT_EST, CFG_DATA_W'(0));
                end
                3: begin
                    // alpha above one saturates
                    cfg_write(CFG_POLICY, CFG_DATA_W'(0));
                    cfg_write(CFG_ALPHA, CFG_DATA_W'(511));
                    cfg_write(CFG_INIT_EST, CFG_DATA_W'($urandom_range(1, 24'hFFFFFF)));
                end
                4: begin
                    cfg_write(CFG_POLICY, CFG_DATA_W'(1));
                    cfg_write(CFG_ALPHA, CFG_DATA_W'($urandom_range(0, 511)));
                    cfg_write(CFG_INIT_EST, CFG_DATA_W'($urandom_range(1, 100000)));
                end
                default: begin
                    cfg_write(CFG_POLICY, CFG_DATA_W'(POLICY_RST));
                    cfg_write(CFG_ALPHA, CFG_DATA_W'(ALPHA_RST));
                    cfg_write(CFG_INIT_EST, CFG_DATA_W'(INIT_EST_RST));
                end
            endcase
            random_traffic(ITEMS_PER_PHASE);
            drain_block();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests over %0d register settings, FIFO and ratio dispatch",
                 sent_count, NUM_PHASES + 1);
        $display("%0d results checked (%0d full, %0d empty replies), %0d mismatches",
                 checked, full_seen, empty_seen, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ hrrn_ready_queue_scheduler_top.f @@
rtl/hrrn_pkg.sv
rtl/hrrn_entry_ram.sv
rtl/hrrn_mul_pair.sv
rtl/hrrn_ready_queue_scheduler_top.sv
tb/hrrn_sched_checker.sv
tb/tb_hrrn_ready_queue_scheduler_top.sv
